/* hw/rtl/tksum_pkg.sv */
// ----------------------------------------------------------------------------
// Top-k sum package
// Sizes, register indexes and shared types of the top-k sum unit.
// ----------------------------------------------------------------------------
package tksum_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int FILL_W   = $clog2(CAPACITY + 1);

   localparam int VALUE_W  = 32;
   localparam int KEPT_W   = 31;
   localparam int SUM_W    = 40;
   localparam int POS_W    = 32;
   localparam int BEST_W   = 48;
   localparam int COUNT_W  = 7;
   localparam int PEN_W    = 20;
   localparam int COST_W   = POS_W + PEN_W;
   localparam int DIFF_W   = COST_W + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY    = 1'd1;

   localparam logic [COUNT_W-1:0] KEEP_COUNT_RESET = 7'd64;

   typedef logic [KEPT_W-1:0] kept_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [FILL_W-1:0] fill_type;

endpackage

/* hw/rtl/tksum_ram.sv */
// ----------------------------------------------------------------------------
// Top-k sum RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tksum_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/topk_sum_with_position_penalty_unit.sv */
// ----------------------------------------------------------------------------
// Top-k sum with position penalty
// Keeps the largest positive values in a min-heap and tracks the best
// penalized sum.
// ----------------------------------------------------------------------------
// Every input word advances the position; positive values enter a min-heap
// of up to keep_count entries (at least one, at most 64) held in a RAM with
// one read port, with the minimum mirrored in a register. A skipped or
// rejected word goes straight to the return of the score. An admitted word
// first passes the penalty multiply and score update, then the heap walk: an
// insert reads and compares the parent at each level climbed, a replacement
// reads both children and compares at each level descended (two reads of the
// one RAM read port and a compare), and then the word is returned. A new word
// is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
module topk_sum_with_position_penalty_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [tksum_pkg::VALUE_W-1:0]  req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tksum_pkg::BEST_W-1:0]          rsp_best_score,
   input  logic                                  csr_wr_en,
   input  logic [tksum_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tksum_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_COST  = 4'd1;
   localparam logic [3:0] ST_SCORE = 4'd2;
   localparam logic [3:0] ST_UP_RD = 4'd3;
   localparam logic [3:0] ST_UP_CM = 4'd4;
   localparam logic [3:0] ST_DN_RL = 4'd5;
   localparam logic [3:0] ST_DN_RR = 4'd6;
   localparam logic [3:0] ST_DN_CM = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]                       state_ff, state_in;
   logic [tksum_pkg::COUNT_W-1:0]    keep_count_ff, keep_count_in;
   logic [tksum_pkg::PEN_W-1:0]      penalty_ff, penalty_in;
   tksum_pkg::fill_type              fill_ff, fill_in;
   logic [tksum_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [tksum_pkg::POS_W-1:0]      position_ff, position_in;
   logic [tksum_pkg::BEST_W-1:0]     best_ff, best_in;
   tksum_pkg::kept_type              root_ff, root_in;
   tksum_pkg::kept_type              value_ff, value_in;
   tksum_pkg::kept_type              left_ff, left_in;
   logic                             has_right_ff, has_right_in;
   logic                             insert_ff, insert_in;
   tksum_pkg::addr_type              idx_ff, idx_in;
   tksum_pkg::fill_type              child_ff, child_in;
   logic [tksum_pkg::COST_W-1:0]     cost_ff, cost_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tksum_pkg::BEST_W-1:0]     rsp_best_ff, rsp_best_in;

   logic                             wr_en;
   tksum_pkg::addr_type              wr_addr;
   tksum_pkg::kept_type              wr_data;
   tksum_pkg::addr_type              rd_addr;
   tksum_pkg::kept_type              rd_data;

   tksum_pkg::fill_type              limit;
   logic                             positive;
   tksum_pkg::kept_type              req_kept;
   tksum_pkg::addr_type              idx_dec;
   tksum_pkg::addr_type              parent;
   tksum_pkg::fill_type              child_next;
   logic signed [tksum_pkg::DIFF_W-1:0] diff;
   tksum_pkg::kept_type              min_val;
   tksum_pkg::fill_type              min_idx;

   tksum_ram #(
      .WIDTH (tksum_pkg::KEPT_W),
      .DEPTH (tksum_pkg::CAPACITY)
   ) u_heap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (keep_count_ff == '0) begin
         limit = tksum_pkg::FILL_W'(1);
      end else if (keep_count_ff > tksum_pkg::COUNT_W'(tksum_pkg::CAPACITY)) begin
         limit = tksum_pkg::FILL_W'(tksum_pkg::CAPACITY);
      end else begin
         limit = tksum_pkg::FILL_W'(keep_count_ff);
      end
   end

   assign positive   = (req_value != '0) && !req_value[tksum_pkg::VALUE_W-1];
   assign req_kept   = req_value[tksum_pkg::KEPT_W-1:0];
   assign idx_dec    = idx_ff - tksum_pkg::ADDR_W'(1);
   assign parent     = {1'b0, idx_dec[tksum_pkg::ADDR_W-1:1]};
   assign child_next = child_ff + tksum_pkg::FILL_W'(1);
   assign diff       = $signed({{(tksum_pkg::DIFF_W - tksum_pkg::SUM_W){1'b0}}, sum_ff})
                     - $signed({1'b0, cost_ff});

   always_comb begin
      if (has_right_ff && (rd_data < left_ff)) begin
         min_val = rd_data;
         min_idx = child_next;
      end else begin
         min_val = left_ff;
         min_idx = child_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      keep_count_in = keep_count_ff;
      penalty_in    = penalty_ff;
      fill_in       = fill_ff;
      sum_in        = sum_ff;
      position_in   = position_ff;
      best_in       = best_ff;
      root_in       = root_ff;
      value_in      = value_ff;
      left_in       = left_ff;
      has_right_in  = has_right_ff;
      insert_in     = insert_ff;
      idx_in        = idx_ff;
      child_in      = child_ff;
      cost_in       = cost_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_best_in   = rsp_best_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = value_ff;
      rd_addr       = parent;

      if (csr_wr_en) begin
         case (csr_index)
            tksum_pkg::CSR_KEEP_COUNT: keep_count_in = csr_wr_data[tksum_pkg::COUNT_W-1:0];
            tksum_pkg::CSR_PENALTY:    penalty_in = csr_wr_data[tksum_pkg::PEN_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               position_in = position_ff + tksum_pkg::POS_W'(1);
               value_in    = req_kept;
               state_in    = ST_DONE;
               if (positive && (fill_ff < limit)) begin
                  insert_in = 1'b1;
                  idx_in    = tksum_pkg::ADDR_W'(fill_ff);
                  fill_in   = fill_ff + tksum_pkg::FILL_W'(1);
                  sum_in    = sum_ff + tksum_pkg::SUM_W'(req_kept);
                  state_in  = ST_COST;
               end else if (positive && (fill_ff != '0) && (req_kept > root_ff)) begin
                  insert_in = 1'b0;
                  idx_in    = '0;
                  child_in  = tksum_pkg::FILL_W'(1);
                  sum_in    = sum_ff - tksum_pkg::SUM_W'(root_ff)
                            + tksum_pkg::SUM_W'(req_kept);
                  state_in  = ST_COST;
               end
            end
         end
         ST_COST: begin
            cost_in  = tksum_pkg::COST_W'(position_ff) * tksum_pkg::COST_W'(penalty_ff);
            state_in = ST_SCORE;
         end
         ST_SCORE: begin
            if ((diff > 0) && (diff[tksum_pkg::BEST_W-1:0] > best_ff)) begin
               best_in = diff[tksum_pkg::BEST_W-1:0];
            end
            state_in = insert_ff ? ST_UP_RD : ST_DN_RL;
         end
         ST_UP_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               root_in  = value_ff;
               state_in = ST_DONE;
            end else begin
               state_in = ST_UP_CM;
            end
         end
         ST_UP_CM: begin
            wr_en = 1'b1;
            if (rd_data <= value_ff) begin
               if (idx_ff == '0) begin
                  root_in = value_ff;
               end
               state_in = ST_DONE;
            end else begin
               wr_data  = rd_data;
               idx_in   = parent;
               state_in = ST_UP_RD;
            end
         end
         ST_DN_RL: begin
            rd_addr = child_ff[tksum_pkg::ADDR_W-1:0];
            if (child_ff < fill_ff) begin
               state_in = ST_DN_RR;
            end else begin
               wr_en = 1'b1;
               if (idx_ff == '0) begin
                  root_in = value_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DN_RR: begin
            rd_addr      = child_next[tksum_pkg::ADDR_W-1:0];
            left_in      = rd_data;
            has_right_in = child_next < fill_ff;
            state_in     = ST_DN_CM;
         end
         ST_DN_CM: begin
            wr_en = 1'b1;
            if (value_ff <= min_val) begin
               if (idx_ff == '0) begin
                  root_in = value_ff;
               end
               state_in = ST_DONE;
            end else begin
               wr_data = min_val;
               if (idx_ff == '0) begin
                  root_in = min_val;
               end
               idx_in   = min_idx[tksum_pkg::ADDR_W-1:0];
               child_in = {min_idx[tksum_pkg::ADDR_W-1:0], 1'b1};
               state_in = ST_DN_RL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = best_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keep_count_ff <= tksum_pkg::KEEP_COUNT_RESET;
         penalty_ff    <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         position_ff   <= '0;
         best_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         keep_count_ff <= keep_count_in;
         penalty_ff    <= penalty_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         position_ff   <= position_in;
         best_ff       <= best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      root_ff      <= root_in;
      value_ff     <= value_in;
      left_ff      <= left_in;
      has_right_ff <= has_right_in;
      insert_ff    <= insert_in;
      idx_ff       <= idx_in;
      child_ff     <= child_in;
      cost_ff      <= cost_in;
      rsp_best_ff  <= rsp_best_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_score = rsp_best_ff;

endmodule

/* sim/tb_topk_sum_with_position_penalty_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Top-k sum with position penalty testbench
// Streams signed words through the unit under changing keep counts and
// penalties, predicts the best penalized top-k sum after every word and
// checks each returned score, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_topk_sum_with_position_penalty_unit;
   import tksum_pkg::*;

   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int NUM_PHASES      = 8;
   localparam int WORDS_PER_PHASE = 150;
   localparam int STEADY_PHASE    = 2;
   localparam int HOLD_PHASE      = 4;
   localparam int PAUSE_PHASE     = 5;
   localparam int MAX_REPORTS     = 20;

   typedef enum logic [1:0] {STEP_WORD, STEP_KEEP, STEP_PENALTY} step_kind_e;

   typedef struct packed {
      step_kind_e        kind;
      logic [31:0]       data;
      logic              known;
      logic [BEST_W-1:0] best;
   } step_t;

   localparam int NUM_STEPS = 23;
   localparam step_t DIRECTED [NUM_STEPS] = '{
      '{STEP_WORD,    32'h0000_0000, 1'b1, 48'd0},
      '{STEP_WORD,    32'h8000_0000, 1'b1, 48'd0},
      '{STEP_WORD,    32'hFFFF_FFFF, 1'b1, 48'd0},
      '{STEP_WORD,    32'h7FFF_FFFF, 1'b1, 48'd2147483647},
      '{STEP_WORD,    32'h0000_0001, 1'b1, 48'd2147483648},
      '{STEP_KEEP,    32'h0000_0001, 1'b0, 48'd0},
      '{STEP_WORD,    32'h0000_0001, 1'b1, 48'd2147483648},
      '{STEP_WORD,    32'h0000_0005, 1'b1, 48'd2147483652},
      '{STEP_PENALTY, 32'h000F_FFFF, 1'b0, 48'd0},
      '{STEP_WORD,    32'h0000_0006, 1'b0, 48'd0},
      '{STEP_WORD,    32'h7FFF_FFFF, 1'b0, 48'd0},
      '{STEP_KEEP,    32'h0000_0000, 1'b0, 48'd0},
      '{STEP_WORD,    32'h0000_0064, 1'b0, 48'd0},
      '{STEP_WORD,    32'h7FFF_FFFF, 1'b0, 48'd0},
      '{STEP_KEEP,    32'h000A_A7FF, 1'b0, 48'd0},
      '{STEP_PENALTY, 32'h0000_0000, 1'b0, 48'd0},
      '{STEP_WORD,    32'h4000_0000, 1'b0, 48'd0},
      '{STEP_WORD,    32'h0000_0002, 1'b0, 48'd0},
      '{STEP_KEEP,    32'h0005_5582, 1'b0, 48'd0},
      '{STEP_WORD,    32'h0000_0003, 1'b0, 48'd0},
      '{STEP_PENALTY, 32'h0005_5555, 1'b0, 48'd0},
      '{STEP_WORD,    32'h2AAA_AAAA, 1'b0, 48'd0},
      '{STEP_WORD,    32'h7FFF_FFFE, 1'b0, 48'd0}
   };

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   logic signed [VALUE_W-1:0]    req_value   = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   logic [BEST_W-1:0]            rsp_best_score;
   logic                         csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index   = CSR_KEEP_COUNT;
   logic [CSR_DATA_W-1:0]        csr_wr_data = '0;

   // predicted unit state
   kept_type                     kept_vals[$];
   logic [SUM_W-1:0]             kept_total      = '0;
   logic [POS_W-1:0]             item_pos        = '0;
   logic [BEST_W-1:0]            best_seen       = '0;
   logic [COUNT_W-1:0]           keep_setting    = KEEP_COUNT_RESET;
   logic [PEN_W-1:0]             penalty_setting = '0;

   logic [BEST_W-1:0]            expected_best_q[$];
   int                           error_count   = 0;
   int                           words_sent    = 0;
   int                           admitted      = 0;
   int                           scores_seen   = 0;
   int                           csr_writes    = 0;
   int                           hold_requests = 0;
   int                           holds_served  = 0;
   int                           hold_left     = 0;
   int                           quiet_cycles  = 0;
   logic                         steady_run    = 1'b0;

   topk_sum_with_position_penalty_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_score (rsp_best_score),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void raise_best(input logic [SUM_W-1:0] total);
      longint score;
      score = longint'(total) - longint'(item_pos) * longint'(penalty_setting);
      if (score > 0 && score > longint'(best_seen))
         best_seen = score[BEST_W-1:0];
   endfunction

   function automatic void keep_value(input kept_type v);
      int slot;
      slot = 0;
      while (slot < kept_vals.size() && kept_vals[slot] <= v)
         slot++;
      kept_vals.insert(slot, v);
   endfunction

   function automatic logic [BEST_W-1:0] predict_best(input logic signed [VALUE_W-1:0] word);
      int unsigned limit;
      kept_type    fresh;
      limit = (keep_setting == 0) ? 1 :
              ((keep_setting > CAPACITY) ? CAPACITY : keep_setting);
      fresh = word[KEPT_W-1:0];
      item_pos = item_pos + POS_W'(1);
      if (word > 0) begin
         if (kept_vals.size() < limit) begin
            raise_best(kept_total + SUM_W'(fresh));
            kept_total = kept_total + SUM_W'(fresh);
            keep_value(fresh);
            admitted++;
         end else if (kept_vals.size() > 0 && fresh > kept_vals[0]) begin
            kept_total = kept_total - SUM_W'(kept_vals[0]) + SUM_W'(fresh);
            raise_best(kept_total);
            void'(kept_vals.pop_front());
            keep_value(fresh);
            admitted++;
         end
      end
      return best_seen;
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 12)      return $urandom() | 32'h8000_0000;
      else if (pick < 15) return 32'h0000_0000;
      else if (pick < 17) return 32'h8000_0000;
      else if (pick < 25) return $urandom_range(16, 1);
      else if (pick < 28) return 32'h7FFF_FFFF;
      else if (pick < 35) return 32'h7FFF_FFFF - $urandom_range(15, 0);
      else                return $urandom() & 32'h7FFF_FFFF;
   endfunction

   // hold off until every score is back and the unit has gone quiet
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_best_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_KEEP_COUNT)
         keep_setting = data[COUNT_W-1:0];
      else
         penalty_setting = data[PEN_W-1:0];
      csr_writes++;
   endtask

   task automatic send_word(input logic signed [VALUE_W-1:0] word,
                            input logic known, input logic [BEST_W-1:0] typed_best);
      logic [BEST_W-1:0] predicted;
      while (!steady_run && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = predict_best(word);
      expected_best_q.push_back(known ? typed_best : predicted);
      words_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scores_seen++;
         if (expected_best_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected score %0d with nothing pending",
                        $time, rsp_best_score);
         end else begin
            logic [BEST_W-1:0] want;
            want = expected_best_q.pop_front();
            if (rsp_best_score !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: best_score mismatch: expected %0d, got %0d",
                           $time, want, rsp_best_score);
            end
         end
      end
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else
         rsp_stall <= !steady_run && ($urandom_range(99) < 28);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      logic [COUNT_W-1:0]    keep;
      logic [PEN_W-1:0]      pen;
      logic [CSR_DATA_W-1:0] csr_data;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_STEPS; i++) begin
         case (DIRECTED[i].kind)
            STEP_KEEP:    write_register(CSR_KEEP_COUNT, DIRECTED[i].data[CSR_DATA_W-1:0]);
            STEP_PENALTY: write_register(CSR_PENALTY, DIRECTED[i].data[CSR_DATA_W-1:0]);
            default:      send_word(DIRECTED[i].data, DIRECTED[i].known, DIRECTED[i].best);
         endcase
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin keep = 7'd64;  pen = '0;                               end
            1: begin keep = 7'd1;   pen = 20'hF_FFFF;                       end
            2: begin keep = 7'd0;   pen = PEN_W'($urandom_range(255));      end
            3: begin keep = 7'd127; pen = '0;                               end
            4: begin keep = 7'd2;   pen = PEN_W'($urandom());               end
            5: begin
               keep = COUNT_W'($urandom_range(63, 3));
               pen  = PEN_W'($urandom_range(1023));
            end
            6: begin keep = 7'd7;   pen = '0;                               end
            default: begin
               keep = COUNT_W'($urandom_range(64, 1));
               pen  = PEN_W'($urandom_range(15));
            end
         endcase
         csr_data = CSR_DATA_W'($urandom());
         csr_data[COUNT_W-1:0] = keep;
         write_register(CSR_KEEP_COUNT, csr_data);
         write_register(CSR_PENALTY, pen);
         steady_run <= (phase == STEADY_PHASE);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (phase == HOLD_PHASE && n == 10)
               hold_requests <= hold_requests + 1;
            if (phase == PAUSE_PHASE && n == WORDS_PER_PHASE / 2)
               drain_block();
            send_word(random_word(), 1'b0, '0);
         end
      end

      drain_block();
      $display("Streamed %0d words (%0d admitted) across %0d register writes.",
               words_sent, admitted, csr_writes);
      $display("Checked %0d scores; final best %0d with %0d values kept.",
               scores_seen, best_seen, kept_vals.size());
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/tksum_pkg.sv
hw/rtl/tksum_ram.sv
hw/rtl/topk_sum_with_position_penalty_unit.sv
sim/tb_topk_sum_with_position_penalty_unit.sv
